// ----- src/ats_pkg.sv -----
// shared types and constants for the adaptive threshold sparsifier
// no dependencies
package ats_pkg;
   localparam int unsigned TENSOR_SLOTS_DEF = 16;
   localparam int unsigned MAX_ELEMENTS_DEF = 16777216;

   localparam logic [1:0] CSR_INIT_THR = 2'd0;
   localparam logic [1:0] CSR_DEC_FACT = 2'd1;
   localparam logic [1:0] CSR_INC_GAIN = 2'd2;

   localparam logic [31:0] INIT_THR_RST = 32'd167772;
   localparam logic [15:0] DEC_FACT_RST = 16'd64881;
   localparam logic [15:0] INC_GAIN_RST = 16'd655;

   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [3:0]  tensor_slot;
      logic signed [31:0] sample_value;
      logic        final_element;
      logic [24:0] target_count;
      logic [24:0] capacity;
      logic [31:0] index_base;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] out_index;
      logic signed [31:0] out_value;
      logic [24:0] emitted_count;
      logic [31:0] updated_threshold;
      logic        run_end;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_MUL, ST_SUM, ST_SEND
   } state_type;

   // update unit sequencing and the kind of update it applies
   typedef enum logic [2:0] {
      U_IDLE, U_DIV, U_MULLO, U_MULHI, U_ADD, U_DONE
   } upd_state_type;

   typedef enum logic [1:0] {
      MODE_HOLD, MODE_DEC, MODE_INC
   } upd_mode_type;

   // request to the update unit
   typedef struct packed {
      logic        start;
      logic [31:0] thr;
      logic [24:0] count;
      logic [24:0] target;
      logic [31:0] maxm;
   } upd_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] thr;
   } upd_rsp_type;
endpackage

// ----- src/ats_if.sv -----
// valid/ready channel carrying one word
// depends on ats_pkg
interface ats_if #(parameter type word_type = logic) (input logic clock);
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- src/ats_update.sv -----
// aimd threshold update: multiplicative decrease, or serial divide, then split multiply and saturating add
// depends on ats_pkg
module ats_update (
   input  logic clock,
   input  logic reset,
   input  logic [15:0] dec_fact,
   input  logic [15:0] inc_gain,
   input  ats_pkg::upd_req_type upd_req,
   output ats_pkg::upd_rsp_type upd_rsp
);
   import ats_pkg::*;

   upd_state_type st_ff, st_in;
   logic [40:0] rem_ff, rem_in;      // dividend shifting out / quotient shifting in
   logic [24:0] part_ff, part_in;    // partial remainder
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] thr_ff, thr_in;
   logic [24:0] div_ff, div_in;
   logic [31:0] maxm_ff, maxm_in;
   logic [63:0] acc_ff, acc_in;
   upd_mode_type mode_ff, mode_in;
   logic [25:0] trial;
   logic [56:0] prod_lo;
   logic [56:0] prod_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= U_IDLE;
      end else begin
         st_ff <= st_in;
      end
      rem_ff <= rem_in; part_ff <= part_in; cnt_ff <= cnt_in;
      thr_ff <= thr_in; div_ff <= div_in; maxm_ff <= maxm_in;
      acc_ff <= acc_in; mode_ff <= mode_in;
   end

   always_comb begin
      st_in = st_ff; rem_in = rem_ff; part_in = part_ff; cnt_in = cnt_ff;
      thr_in = thr_ff; div_in = div_ff; maxm_in = maxm_ff; acc_in = acc_ff;
      mode_in = mode_ff;
      upd_rsp.done = 1'b0;
      upd_rsp.thr = thr_ff;
      trial = {part_ff, rem_ff[40]} - {1'b0, div_ff};
      prod_lo = 57'(rem_ff) * 57'(maxm_ff[15:0]);
      prod_hi = 57'(rem_ff) * 57'(maxm_ff[31:16]);
      unique case (st_ff)
         U_IDLE: begin
            if (upd_req.start) begin
               thr_in = upd_req.thr;
               maxm_in = upd_req.maxm;
               div_in = (upd_req.target == 25'd0) ? 25'd1 : upd_req.target;
               rem_in = 41'(inc_gain) * 41'(upd_req.count);
               part_in = '0;
               cnt_in = 6'd41;
               if (div_in > upd_req.count) begin
                  mode_in = MODE_DEC;
                  acc_in = 64'(upd_req.thr) * 64'(dec_fact);
                  st_in = U_ADD;
               end else if (div_in < upd_req.count) begin
                  mode_in = MODE_INC;
                  st_in = U_DIV;
               end else begin
                  mode_in = MODE_HOLD;
                  st_in = U_DONE;
               end
            end
         end
         U_DIV: begin
            // restoring division, one quotient bit a cycle
            if (!trial[25]) begin
               part_in = trial[24:0];
               rem_in = {rem_ff[39:0], 1'b1};
            end else begin
               part_in = {part_ff[23:0], rem_ff[40]};
               rem_in = {rem_ff[39:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) st_in = U_MULLO;
         end
         U_MULLO: begin
            acc_in = 64'(prod_lo[56:16]);
            st_in = U_MULHI;
         end
         U_MULHI: begin
            acc_in = acc_ff + 64'(prod_hi);
            st_in = U_ADD;
         end
         U_ADD: begin
            if (mode_ff == MODE_DEC) begin
               thr_in = acc_ff[47:16];
            end else begin
               acc_in = acc_ff + 64'(thr_ff);
               thr_in = (acc_in[63:32] != '0) ? 32'hFFFF_FFFF : acc_in[31:0];
            end
            st_in = U_DONE;
         end
         U_DONE: begin
            upd_rsp.done = 1'b1;
            st_in = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end
endmodule

// ----- src/ats_core.sv -----
// sequencer: slot table memory, per-tensor counters, result queue of two
// depends on ats_pkg, ats_update
module ats_core #(
   parameter int unsigned TENSOR_SLOTS = ats_pkg::TENSOR_SLOTS_DEF,
   parameter int unsigned MAX_ELEMENTS = ats_pkg::MAX_ELEMENTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [31:0] init_thr,
   input  logic [15:0] dec_fact,
   input  logic [15:0] inc_gain,
   ats_if.sink   req,
   ats_if.source rsp
);
   import ats_pkg::*;

   localparam int SW = (TENSOR_SLOTS > 1) ? $clog2(TENSOR_SLOTS) : 1;
   localparam int PW = $clog2(MAX_ELEMENTS);

   logic [31:0] thr_mem [TENSOR_SLOTS];
   logic [31:0] rd_ff;
   logic [TENSOR_SLOTS-1:0] valid_ff, valid_in;
   state_type st_ff, st_in;
   req_word_type cur_ff, cur_in;
   logic [SW-1:0] slot;
   logic [PW-1:0] pos_ff, pos_in;
   logic [24:0] cnt_ff, cnt_in;
   logic [31:0] max_ff, max_in;
   rsp_word_type q_ff [2];
   rsp_word_type q_in [2];
   logic [1:0]  qn_ff, qn_in;
   logic        qh_ff, qh_in;
   logic        wr_en;
   logic [31:0] thr_use, mag;
   upd_req_type upd_req;
   upd_rsp_type upd_rsp;

   // slot field folded onto the table depth, a mux of constants
   always_comb begin
      slot = '0;
      for (int i = 0; i < 16; i++) begin
         if (cur_ff.tensor_slot == 4'(i)) slot = SW'(i % TENSOR_SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) thr_mem[slot] <= upd_rsp.thr;
      rd_ff <= thr_mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; valid_ff <= '0; pos_ff <= '0; cnt_ff <= '0;
         max_ff <= '0; qn_ff <= '0; qh_ff <= 1'b0;
      end else begin
         st_ff <= st_in; valid_ff <= valid_in; pos_ff <= pos_in; cnt_ff <= cnt_in;
         max_ff <= max_in; qn_ff <= qn_in; qh_ff <= qh_in;
      end
      cur_ff <= cur_in;
      q_ff <= q_in;
   end

   ats_update u_update (
      .clock, .reset, .dec_fact, .inc_gain, .upd_req, .upd_rsp
   );

   assign rsp.valid = (qn_ff != 2'd0);
   assign rsp.word = q_ff[qh_ff];
   assign mag = cur_ff.sample_value[31] ? (~cur_ff.sample_value + 32'd1)
                                         : cur_ff.sample_value;
   assign thr_use = valid_ff[slot] ? rd_ff : init_thr;

   always_comb begin
      rsp_word_type w;
      st_in = st_ff; cur_in = cur_ff; valid_in = valid_ff; pos_in = pos_ff;
      cnt_in = cnt_ff; max_in = max_ff; q_in = q_ff; qn_in = qn_ff; qh_in = qh_ff;
      wr_en = 1'b0;
      req.ready = 1'b0;
      upd_req = '{start: 1'b0, thr: thr_use, count: cnt_ff,
                  target: cur_ff.target_count, maxm: max_ff};
      w = '0;
      if (rsp.valid && rsp.ready) begin
         qh_in = ~qh_ff;
         qn_in = qn_ff - 2'd1;
      end
      unique case (st_ff)
         ST_IDLE: begin
            // queue may still hold a word; two slots allow one more item
            req.ready = (qn_in != 2'd2);
            if (req.valid && req.ready) begin
               cur_in = req.word;
               st_in = ST_READ;
            end
         end
         ST_READ: st_in = ST_EVAL;
         ST_EVAL: begin
            if (mag > max_ff) max_in = mag;
            if (mag >= thr_use) begin
               if (cnt_ff < cur_ff.capacity) begin
                  w.result_kind = KIND_ELEMENT;
                  w.out_index = cur_ff.index_base + 32'(pos_ff);
                  w.out_value = cur_ff.sample_value;
                  w.run_end = ~cur_ff.final_element;
                  q_in[qh_in ^ qn_in[0]] = w;
                  qn_in = qn_in + 2'd1;
               end
               if (cnt_ff != 25'h1FF_FFFF) cnt_in = cnt_ff + 25'd1;
            end
            if (cur_ff.final_element) begin
               st_in = ST_DIV;
            end else begin
               pos_in = (32'(pos_ff) == MAX_ELEMENTS - 1) ? '0 : pos_ff + PW'(1);
               st_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            upd_req.start = 1'b1;
            st_in = ST_MUL;
         end
         ST_MUL: begin
            if (upd_rsp.done) st_in = ST_SEND;
         end
         ST_SEND: begin
            if (qn_in != 2'd2) begin
               w.result_kind = KIND_SUMMARY;
               w.emitted_count = (cnt_ff < cur_ff.capacity) ? cnt_ff : cur_ff.capacity;
               w.updated_threshold = upd_rsp.thr;
               w.run_end = 1'b1;
               q_in[qh_in ^ qn_in[0]] = w;
               qn_in = qn_in + 2'd1;
               wr_en = 1'b1;
               valid_in[slot] = 1'b1;
               pos_in = '0; cnt_in = '0; max_in = '0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end
endmodule

// ----- src/adaptive_threshold_sparsifier.sv -----
// adaptive threshold sparsifier: an element passes idle, read and eval; a final element
// also passes div, mul (waiting on the update unit's 41-step serial divider) and send,
// with the slot threshold memory read ahead of the compare; two-word output queue
// input accepted while the queue has a free entry, so one waiting word does not block it
// synchronous reset clears slot valid bits, counters, queue; registers to defaults
module adaptive_threshold_sparsifier #(
   parameter int unsigned TENSOR_SLOTS = ats_pkg::TENSOR_SLOTS_DEF,
   parameter int unsigned MAX_ELEMENTS = ats_pkg::MAX_ELEMENTS_DEF
) (
   input  logic clock,
   input  logic reset,
   ats_if.sink   req,
   ats_if.source rsp,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ats_pkg::*;

   logic [31:0] init_thr_ff;
   logic [15:0] dec_fact_ff, inc_gain_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_thr_ff <= INIT_THR_RST;
         dec_fact_ff <= DEC_FACT_RST;
         inc_gain_ff <= INC_GAIN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INIT_THR: init_thr_ff <= csr_data;
            CSR_DEC_FACT: dec_fact_ff <= csr_data[15:0];
            CSR_INC_GAIN: inc_gain_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   ats_core #(.TENSOR_SLOTS(TENSOR_SLOTS), .MAX_ELEMENTS(MAX_ELEMENTS)) u_core (
      .clock, .reset, .init_thr(init_thr_ff), .dec_fact(dec_fact_ff),
      .inc_gain(inc_gain_ff), .req, .rsp
   );
endmodule

// ----- src/ats_checker.sv -----
// port-level checks for the sparsifier
// depends on ats_pkg; bound to adaptive_threshold_sparsifier
module ats_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input ats_pkg::rsp_word_type rsp_word
);
   import ats_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled word changed");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted twice in a row");
   a_sum_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_SUMMARY |-> rsp_word.run_end)
      else $error("summary without run end");
   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_ELEMENT |->
      rsp_word.emitted_count == '0 && rsp_word.updated_threshold == '0)
      else $error("element word carries summary fields");
endmodule

bind adaptive_threshold_sparsifier ats_checker u_ats_checker (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.word)
);

// ----- bench/testbench.sv -----
// self-checking bench for the adaptive threshold sparsifier
// depends on ats_pkg, ats_if and the block; drives words, predicts and checks results
`timescale 1ns / 1ps
module testbench;
   import ats_pkg::*;

   logic clock;
   logic reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   ats_if #(.word_type(req_word_type)) req_ch (.clock(clock));
   ats_if #(.word_type(rsp_word_type)) rsp_ch (.clock(clock));

   adaptive_threshold_sparsifier dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [31:0] thr_table [16];
   logic        slot_seen [16];
   logic [23:0] position;
   logic [24:0] match_cnt;
   logic [31:0] peak_mag;
   logic [31:0] init_thr;
   logic [15:0] dec_fact;
   logic [15:0] inc_gain;

   req_word_type pending_words [$];
   rsp_word_type expected_words [$];

   int send_idle_pct;
   int recv_idle_pct;
   bit recv_block = 1'b0;  // long receiver hold-off in progress
   bit send_pause;      // sender waits until every result has come
   int mismatches = 0;
   int cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // new threshold after a tensor ends
   function automatic logic [31:0] next_threshold(logic [31:0] t, logic [24:0] count,
                                                  logic [24:0] target, logic [31:0] maxm);
      logic [63:0] k;
      logic [63:0] ratio;
      logic [63:0] inc;
      logic [63:0] sum;
      k = (target == 0) ? 64'd1 : {39'd0, target};
      if (k > count) return 32'((64'(t) * dec_fact) >> 16);
      if (k < count) begin
         ratio = (64'(inc_gain) * count) / k;
         inc = ratio * (maxm >> 16) + ((ratio * (maxm & 32'hffff)) >> 16);
         sum = 64'(t) + inc;
         return (sum > 64'hffffffff) ? 32'hffffffff : sum[31:0];
      end
      return t;
   endfunction

   // works out the result words one accepted word causes
   task automatic predict_word(req_word_type w);
      logic [3:0]  s;
      logic [31:0] thr;
      logic [31:0] mag;
      logic [31:0] nt;
      rsp_word_type r;
      s = w.tensor_slot;
      thr = slot_seen[s] ? thr_table[s] : init_thr;
      mag = w.sample_value[31] ? -w.sample_value : w.sample_value;
      if (mag > peak_mag) peak_mag = mag;
      if (mag >= thr) begin
         if (match_cnt < w.capacity) begin
            r = '0;
            r.result_kind = KIND_ELEMENT;
            r.out_index = 32'(position) + w.index_base;
            r.out_value = w.sample_value;
            r.run_end = !w.final_element;
            expected_words.push_back(r);
         end
         if (match_cnt != 25'h1ffffff) match_cnt++;
      end
      if (w.final_element) begin
         nt = next_threshold(thr, match_cnt, w.target_count, peak_mag);
         r = '0;
         r.result_kind = KIND_SUMMARY;
         r.emitted_count = (match_cnt < w.capacity) ? match_cnt : w.capacity;
         r.updated_threshold = nt;
         r.run_end = 1'b1;
         expected_words.push_back(r);
         thr_table[s] = nt;
         slot_seen[s] = 1'b1;
         position = '0;
         match_cnt = '0;
         peak_mag = '0;
      end else begin
         position++;
      end
   endtask

   // driver: offers the head of the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_word(req_ch.word);
            void'(pending_words.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered word
         end else if (pending_words.size() > (req_ch.valid && req_ch.ready ? 0 : 0)
                      && !send_pause && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.word <= pending_words[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: checks every accepted result word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      rsp_word_type a;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            a = rsp_ch.word;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", a);
            end else begin
               e = expected_words.pop_front();
               if (a.result_kind !== e.result_kind || a.out_index !== e.out_index ||
                   a.out_value !== e.out_value || a.emitted_count !== e.emitted_count ||
                   a.updated_threshold !== e.updated_threshold || a.run_end !== e.run_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", e, a);
               end
            end
         end
         if (recv_block) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_ch.valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_INIT_THR: init_thr = val;
         CSR_DEC_FACT: dec_fact = val[15:0];
         CSR_INC_GAIN: inc_gain = val[15:0];
         default: ;
      endcase
   endtask

   function automatic req_word_type make_word(logic [3:0] s, logic [31:0] v, bit fin,
                                              logic [24:0] tgt, logic [24:0] cap,
                                              logic [31:0] base);
      req_word_type w;
      w.tensor_slot = s;
      w.sample_value = v;
      w.final_element = fin;
      w.target_count = tgt;
      w.capacity = cap;
      w.index_base = base;
      return w;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(400000);
         2: return -$urandom_range(400000);
         3: return 32'h80000000;
         4: return 32'h7fffffff;
         default: return $urandom_range(2000000) - 1000000;
      endcase
   endfunction

   // a tensor of random length with shared target, capacity and base
   task automatic queue_tensor(int len);
      logic [3:0]  s;
      logic [24:0] tgt;
      logic [24:0] cap;
      logic [31:0] base;
      s = $urandom_range(15);
      tgt = ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(6));
      if ($urandom_range(19) == 0) tgt = 25'd16777216;
      cap = ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(8));
      if ($urandom_range(19) == 0) cap = 25'd16777216;
      base = $urandom;
      for (int i = 0; i < len; i++) begin
         // occasional slot change mid tensor
         if ($urandom_range(15) == 0) s = $urandom_range(15);
         pending_words.push_back(make_word(s, rand_value(), i == len - 1, tgt, cap, base));
      end
   endtask

   task automatic random_phase(int count);
      int queued;
      queued = 0;
      while (queued < count) begin
         int len;
         len = $urandom_range(1, 12);
         queue_tensor(len);
         queued += len;
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_pause = 1'b0;
      for (int i = 0; i < 16; i++) begin
         thr_table[i] = '0;
         slot_seen[i] = 1'b0;
      end
      position = '0;
      match_cnt = '0;
      peak_mag = '0;
      init_thr = INIT_THR_RST;
      dec_fact = DEC_FACT_RST;
      inc_gain = INC_GAIN_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, capacity zero, target zero, exact target
      pending_words.push_back(make_word(4'd0, 32'h80000000, 0, 25'd1, 25'd0, 32'hffffffff));
      pending_words.push_back(make_word(4'd0, 32'h7fffffff, 0, 25'd1, 25'd0, 32'hffffffff));
      pending_words.push_back(make_word(4'd0, 32'h00000000, 1, 25'd0, 25'd0, 32'hffffffff));
      pending_words.push_back(make_word(4'd15, 32'h7fffffff, 0, 25'd16777216, 25'd16777216,
                                        32'hfffffffe));
      pending_words.push_back(make_word(4'd15, 32'h80000000, 1, 25'd16777216, 25'd16777216,
                                        32'hfffffffe));
      pending_words.push_back(make_word(4'd3, 32'h01000000, 0, 25'd2, 25'd1, 32'd0));
      pending_words.push_back(make_word(4'd3, 32'hff000000, 0, 25'd2, 25'd1, 32'd0));
      pending_words.push_back(make_word(4'd3, 32'd5, 1, 25'd2, 25'd1, 32'd0));
      pending_words.push_back(make_word(4'd3, 32'h00028f5c, 1, 25'd1, 25'd1, 32'd10));
      pending_words.push_back(make_word(4'd3, 32'hfffd70a4, 1, 25'd1, 25'd1, 32'd10));
      pending_words.push_back(make_word(4'd7, 32'h10000000, 0, 25'd1, 25'd9, 32'd100));
      pending_words.push_back(make_word(4'd8, 32'hf0000000, 0, 25'd1, 25'd9, 32'd100));
      pending_words.push_back(make_word(4'd7, 32'h7fffffff, 1, 25'd1, 25'd9, 32'd100));
      wait_drained();

      // registers at extremes
      write_reg(CSR_INIT_THR, 32'hffffffff);
      write_reg(CSR_DEC_FACT, 32'h0000ffff);
      write_reg(CSR_INC_GAIN, 32'h0000ffff);
      pending_words.push_back(make_word(4'd9, 32'h80000000, 0, 25'd1, 25'd4, 32'd0));
      pending_words.push_back(make_word(4'd9, 32'h7fffffff, 1, 25'd1, 25'd4, 32'd0));
      pending_words.push_back(make_word(4'd10, 32'h80000000, 1, 25'd0, 25'd4, 32'd0));
      wait_drained();
      write_reg(CSR_INIT_THR, 32'd0);
      write_reg(CSR_DEC_FACT, 32'd0);
      write_reg(CSR_INC_GAIN, 32'd0);
      pending_words.push_back(make_word(4'd11, 32'd0, 0, 25'd1, 25'd1, 32'd0));
      pending_words.push_back(make_word(4'd11, 32'd1, 1, 25'd1, 25'd1, 32'd0));
      pending_words.push_back(make_word(4'd12, 32'd3, 1, 25'd5, 25'd5, 32'd0));
      wait_drained();
      write_reg(CSR_INIT_THR, 32'd200000);
      write_reg(CSR_DEC_FACT, 32'd60000);
      write_reg(CSR_INC_GAIN, 32'd3000);

      // random: receiver idles more than sender
      send_idle_pct = 32;
      recv_idle_pct = 45;
      random_phase(500);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            recv_block = 1'b1;
            repeat (400) @(posedge clock);
            recv_block = 1'b0;
         end
      join_none
      random_phase(60);
      wait_drained();

      write_reg(CSR_INIT_THR, $urandom);
      write_reg(CSR_DEC_FACT, $urandom_range(65535));
      write_reg(CSR_INC_GAIN, $urandom_range(65535));
      send_idle_pct = 45;
      recv_idle_pct = 32;
      random_phase(450);

      // sender pause until every result has come
      send_pause = 1'b1;
      while (expected_words.size() != 0 || pending_words.size() != 0 && req_ch.valid)
         @(posedge clock);
      send_pause = 1'b0;
      wait_drained();

      write_reg(CSR_INIT_THR, INIT_THR_RST);
      write_reg(CSR_DEC_FACT, DEC_FACT_RST);
      write_reg(CSR_INC_GAIN, INC_GAIN_RST);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(420);
      wait_drained();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
